/* src/svie_pkg.sv */
// ----------------------------------------------------------------------------
// Sprite VM executor package
// Shared payload types and status codes for the sprite VM execution core.
// ----------------------------------------------------------------------------
package svie_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [11:0] load_address;
        logic [7:0]  load_byte;
        logic [7:0]  random_byte;
        logic [15:0] keys_down;
        logic [4:0]  row_select;
    } in_word_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [15:0] opcode;
        logic [15:0] index_value;
        logic [7:0]  target_value;
        logic [7:0]  flag_value;
        logic        display_changed;
        logic [63:0] display_row;
        logic [1:0]  status;
    } out_word_t;

    localparam logic [1:0] MODE_LOAD = 2'd0;
    localparam logic [1:0] MODE_EXEC = 2'd1;
    localparam logic [1:0] MODE_ROW  = 2'd2;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_OP    = 2'd1;
    localparam logic [1:0] ST_OVERFLOW  = 2'd2;
    localparam logic [1:0] ST_UNDERFLOW = 2'd3;

    localparam logic [11:0] RESET_START = 12'd512;

    // Program memory size; addresses wrap by dropping the upper bits.
    localparam int MEMORY_BYTES = 4096;

endpackage

/* src/svie_ram.sv */
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module svie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

/* src/sprite_vm_instruction_executor.sv */
// ----------------------------------------------------------------------------
// Sprite VM instruction executor
// Execution core for the 8-bit sprite virtual machine.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (in_valid/in_ready/in_data) takes one word per item:
//   a memory load, one instruction to execute, or a display row read. Each
//   item yields exactly one word on the output channel (out_valid/out_ready/
//   out_data). The core works on one item at a time; in_ready is low while
//   an item is in progress or its result has not been taken.
//   A load passes through S_EXEC and a row read through S_ROW, each then S_DONE;
//   a plain instruction goes through S_FHI, S_FLO, S_DEC, S_EXEC and S_DONE (two
//   byte fetches through the single memory read port). DRW repeats S_DRD and
//   S_DRW per sprite row and FX65 repeats S_LDM and S_LDW per byte loaded; CLS
//   clears one framebuffer row a cycle and ties with a 16-byte FX65 as the
//   longest instruction. With the receiver ready, the next word is taken once
//   the result is accepted. The memory read port and framebuffer row port set
//   the pace. After reset the core sweeps the framebuffer clear before it
//   takes the first item; configuration writes are taken at any time.
//   When the receiver stalls, the result holds on out_data and no new item
//   is taken until it is accepted.
// ----------------------------------------------------------------------------
module sprite_vm_instruction_executor #(
    parameter int STACK_DEPTH  = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  svie_pkg::in_word_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output svie_pkg::out_word_t  out_data,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [1:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);
    import svie_pkg::*;

    localparam int AW = $clog2(MEMORY_BYTES);
    localparam int SW = $clog2(STACK_DEPTH);

    typedef enum logic [12:0] {
        S_CLEAR = 13'b0000000000001,
        S_IDLE  = 13'b0000000000010,
        S_FHI   = 13'b0000000000100,
        S_FLO   = 13'b0000000001000,
        S_DEC   = 13'b0000000010000,
        S_EXEC  = 13'b0000000100000,
        S_DRD   = 13'b0000001000000,
        S_DRW   = 13'b0000010000000,
        S_LDM   = 13'b0000100000000,
        S_CLS   = 13'b0001000000000,
        S_ROW   = 13'b0010000000000,
        S_DONE  = 13'b0100000000000,
        S_LDW   = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [11:0] start_reg;
    logic [11:0] pc_reg;
    logic [15:0] idx_reg;
    logic [7:0]  v_reg [16];
    logic [11:0] stk_reg [STACK_DEPTH];
    logic [SW:0] sp_reg;
    logic [7:0]  delay_reg;
    logic [15:0] op_reg;
    logic [4:0]  cnt_reg;
    logic        coll_reg;
    logic        chg_reg;
    logic [1:0]  stat_reg;
    in_word_t    item_reg;
    out_word_t   out_reg;
    logic        out_valid_reg;

    // Memory and framebuffer ports.
    logic          mem_we;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;
    logic          fb_we;
    logic [4:0]    fb_waddr, fb_raddr;
    logic [63:0]   fb_wdata, fb_rdata;

    svie_ram #(.WIDTH(8), .DEPTH(MEMORY_BYTES)) u_mem (
        .clk(clk), .we(mem_we), .waddr(mem_waddr), .wdata(item_reg.load_byte),
        .raddr(mem_raddr), .rdata(mem_rdata)
    );

    svie_ram #(.WIDTH(64), .DEPTH(32)) u_fb (
        .clk(clk), .we(fb_we), .waddr(fb_waddr), .wdata(fb_wdata),
        .raddr(fb_raddr), .rdata(fb_rdata)
    );

    logic [3:0] x, y, n;
    logic [7:0] kk;
    assign x  = op_reg[11:8];
    assign y  = op_reg[7:4];
    assign n  = op_reg[3:0];
    assign kk = op_reg[7:0];

    // Sprite byte from memory placed on the 64-bit row, with wrap. VF is
    // only written when the draw ends, so Vx and Vy hold still meanwhile.
    logic [63:0] spr_mask;
    always_comb
    begin
        logic [127:0] wide;
        wide = {mem_rdata, 120'd0} >> v_reg[x][5:0];
        spr_mask = wide[127:64] | wide[63:0];
    end

    logic [15:0] mem_off;
    assign mem_off = idx_reg + {11'd0, cnt_reg};

    logic row_hit;
    assign row_hit = (fb_rdata & spr_mask) != 64'd0;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign pready    = 1'b1;
    assign prdata    = {20'd0, start_reg};

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && (paddr == 2'd0);

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = item_reg.load_address[AW-1:0];
        mem_raddr = pc_reg[AW-1:0];
        fb_we     = 1'b0;
        fb_waddr  = cnt_reg;
        fb_wdata  = 64'd0;
        fb_raddr  = item_reg.row_select;
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                fb_we = 1'b1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_IDLE;
                end
            end
            S_FHI:
            begin
                mem_raddr = pc_reg[AW-1:0];
                state_next = S_FLO;
            end
            S_FLO:
            begin
                mem_raddr = AW'(pc_reg + 12'd1);
                state_next = S_DEC;
            end
            S_DRD:
            begin
                mem_raddr = mem_off[AW-1:0];
                fb_raddr  = 5'(v_reg[y] + {3'd0, cnt_reg});
            end
            S_DRW:
            begin
                fb_we    = 1'b1;
                fb_waddr = 5'(v_reg[y] + {3'd0, cnt_reg});
                fb_wdata = fb_rdata ^ spr_mask;
            end
            S_LDM:
            begin
                mem_raddr = mem_off[AW-1:0];
            end
            S_CLS:
            begin
                fb_we = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (state_reg == S_EXEC && item_reg.mode == MODE_LOAD)
        begin
            mem_we = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            start_reg     <= RESET_START;
            pc_reg        <= RESET_START;
            idx_reg       <= 16'd0;
            sp_reg        <= '0;
            delay_reg     <= 8'd0;
            cnt_reg       <= 5'd0;
            for (int i = 0; i < 16; i++)
            begin
                v_reg[i] <= 8'd0;
            end
            for (int i = 0; i < STACK_DEPTH; i++)
            begin
                stk_reg[i] <= 12'd0;
            end
        end
        else
        begin
            if (cfg_wr)
            begin
                start_reg <= pwdata[11:0];
            end
            case (state_reg)
                S_CLEAR:
                begin
                    cnt_reg   <= cnt_reg + 5'd1;
                    state_reg <= state_next;
                end
                S_IDLE:
                begin
                    if (in_valid && in_ready)
                    begin
                        item_reg <= in_data;
                        op_reg   <= 16'd0;
                        chg_reg  <= 1'b0;
                        stat_reg <= ST_OK;
                        cnt_reg  <= 5'd0;
                        if (in_data.mode == MODE_EXEC)
                        begin
                            state_reg <= S_FHI;
                        end
                        else
                        begin
                            state_reg <= (in_data.mode == MODE_ROW) ? S_ROW : S_EXEC;
                        end
                    end
                end
                S_ROW:
                begin
                    state_reg <= S_DONE;
                end
                S_FHI:
                begin
                    state_reg <= state_next;
                end
                S_FLO:
                begin
                    op_reg[15:8] <= mem_rdata;
                    state_reg    <= state_next;
                end
                S_DEC:
                begin
                    op_reg[7:0] <= mem_rdata;
                    state_reg   <= S_EXEC;
                end
                S_EXEC:
                begin
                    state_reg <= S_DONE;
                    if (item_reg.mode == MODE_EXEC)
                    begin
                        pc_reg <= pc_reg + 12'd2;
                        case (op_reg[15:12])
                            4'h0:
                            begin
                                if (op_reg == 16'h00E0)
                                begin
                                    chg_reg   <= 1'b1;
                                    state_reg <= S_CLS;
                                end
                                else if (op_reg == 16'h00EE)
                                begin
                                    if (sp_reg == '0)
                                    begin
                                        stat_reg <= ST_UNDERFLOW;
                                    end
                                    else
                                    begin
                                        sp_reg <= sp_reg - 1'b1;
                                        pc_reg <= stk_reg[SW'(sp_reg - 1'b1)] + 12'd2;
                                    end
                                end
                                else
                                begin
                                    stat_reg <= ST_BAD_OP;
                                end
                            end
                            4'h1: pc_reg <= op_reg[11:0];
                            4'h2:
                            begin
                                if (sp_reg >= (SW+1)'(STACK_DEPTH))
                                begin
                                    stat_reg <= ST_OVERFLOW;
                                end
                                else
                                begin
                                    stk_reg[SW'(sp_reg)] <= pc_reg;
                                    sp_reg <= sp_reg + 1'b1;
                                    pc_reg <= op_reg[11:0];
                                end
                            end
                            4'h3:
                            begin
                                if (v_reg[x] == kk) pc_reg <= pc_reg + 12'd4;
                            end
                            4'h4:
                            begin
                                if (v_reg[x] != kk) pc_reg <= pc_reg + 12'd4;
                            end
                            4'h5:
                            begin
                                if (n != 4'd0) stat_reg <= ST_BAD_OP;
                                else if (v_reg[x] == v_reg[y]) pc_reg <= pc_reg + 12'd4;
                            end
                            4'h6: v_reg[x] <= kk;
                            4'h7: v_reg[x] <= v_reg[x] + kk;
                            4'h8:
                            begin
                                if (n == 4'd0) v_reg[x] <= v_reg[y];
                                else if (n == 4'd1) v_reg[x] <= v_reg[x] | v_reg[y];
                                else stat_reg <= ST_BAD_OP;
                            end
                            4'hA: idx_reg <= {4'd0, op_reg[11:0]};
                            4'hC: v_reg[x] <= item_reg.random_byte & kk;
                            4'hD:
                            begin
                                coll_reg <= 1'b0;
                                if (n != 4'd0)
                                begin
                                    state_reg <= S_DRD;
                                end
                                else
                                begin
                                    v_reg[15] <= 8'd0;
                                end
                            end
                            4'hE:
                            begin
                                if (kk == 8'h9E)
                                begin
                                    if (item_reg.keys_down[v_reg[x][3:0]])
                                        pc_reg <= pc_reg + 12'd4;
                                end
                                else if (kk == 8'hA1)
                                begin
                                    if (!item_reg.keys_down[v_reg[x][3:0]])
                                        pc_reg <= pc_reg + 12'd4;
                                end
                                else
                                begin
                                    stat_reg <= ST_BAD_OP;
                                end
                            end
                            4'hF:
                            begin
                                if (kk == 8'h07) v_reg[x] <= delay_reg;
                                else if (kk == 8'h15) delay_reg <= v_reg[x];
                                else if (kk == 8'h1E) idx_reg <= idx_reg + {8'd0, v_reg[x]};
                                else if (kk == 8'h65) state_reg <= S_LDM;
                                else stat_reg <= ST_BAD_OP;
                            end
                            default: stat_reg <= ST_BAD_OP;
                        endcase
                    end
                end
                S_DRD:
                begin
                    // Memory byte and framebuffer row are read here and arrive in S_DRW.
                    state_reg <= S_DRW;
                end
                S_DRW:
                begin
                    if (row_hit) coll_reg <= 1'b1;
                    if (spr_mask != 64'd0) chg_reg <= 1'b1;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == n - 4'd1)
                    begin
                        v_reg[15] <= {7'd0, coll_reg || row_hit};
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_DRD;
                    end
                end
                S_LDM:
                begin
                    state_reg <= S_LDW;
                end
                S_LDW:
                begin
                    v_reg[cnt_reg[3:0]] <= mem_rdata;
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg[3:0] == x)
                    begin
                        idx_reg   <= idx_reg + {12'd0, x} + 16'd1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        state_reg <= S_LDM;
                    end
                end
                S_CLS:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == 5'd31)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_DONE:
                begin
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Result word; the row read uses the registered framebuffer read.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DONE)
        begin
            out_reg.program_counter <= pc_reg;
            out_reg.opcode          <= (item_reg.mode == MODE_EXEC) ? op_reg : 16'd0;
            out_reg.index_value     <= idx_reg;
            out_reg.target_value    <= (item_reg.mode == MODE_EXEC) ? v_reg[x] : 8'd0;
            out_reg.flag_value      <= v_reg[15];
            out_reg.display_changed <= chg_reg;
            out_reg.display_row     <= (item_reg.mode == MODE_ROW) ? fb_rdata : 64'd0;
            out_reg.status          <= stat_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (state_reg == S_DONE)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    ap_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> state_reg == S_IDLE)
        else $error("ready outside idle");
    ap_one_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("second item taken while busy");
    ap_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= (SW+1)'(STACK_DEPTH))
        else $error("stack pointer out of range");
endmodule
